// ===== hw/rtl/pngcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pngcc_pkg
// Shared types, codes and constants for the PNG/MNG/JNG chunk checker.
// ----------------------------------------------------------------------------
package pngcc_pkg;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4
    } t_phase;

    // section codes
    localparam logic [2:0] SEC_SIG     = 3'd0;
    localparam logic [2:0] SEC_LEN     = 3'd1;
    localparam logic [2:0] SEC_TYPE    = 3'd2;
    localparam logic [2:0] SEC_DATA    = 3'd3;
    localparam logic [2:0] SEC_CRC     = 3'd4;
    localparam logic [2:0] SEC_IGNORED = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_BAD_CRC   = 3'd2;
    localparam logic [2:0] ST_END_DATA  = 3'd3;
    localparam logic [2:0] ST_END_CLEAN = 3'd4;

    // file kind codes
    localparam logic [1:0] KIND_PNG  = 2'd0;
    localparam logic [1:0] KIND_MNG  = 2'd1;
    localparam logic [1:0] KIND_JNG  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // smallest legal file: signature, IHDR, one IDAT with 10 bytes, IEND
    localparam logic [6:0] MIN_FILE_BYTES = 7'(8 + 4+4+13+4 + 4+4+10+4 + 4+4+4);

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0] SIG_TABLE [3][8] = '{
        '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10},
        '{8'd138, 8'd77, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10},
        '{8'd139, 8'd74, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10}
    };

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  fbc;         // byte index within the current field
        logic [2:0]  sig_match;   // bit0 PNG, bit1 MNG, bit2 JNG
        logic [31:0] data_rem;
        logic [31:0] crc_run;
        logic [31:0] crc_rcv;
        logic [31:0] chunk_cnt;
        logic [6:0]  bytes_seen;  // saturates at MIN_FILE_BYTES
        logic        stopped;
    } t_parse_state;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  section;
        logic [31:0] chunk_number;
        logic        chunk_done;
        logic [2:0]  status;
        logic [1:0]  file_kind;
    } t_result;

    localparam t_parse_state PARSE_RESET = '{
        phase:      PH_SIG,
        fbc:        3'd0,
        sig_match:  3'b111,
        data_rem:   32'd0,
        crc_run:    CRC_INIT,
        crc_rcv:    32'd0,
        chunk_cnt:  32'd0,
        bytes_seen: 7'd0,
        stopped:    1'b0
    };

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/png_chunk_splitter_crc_check_core.sv =====
// ----------------------------------------------------------------------------
// png_chunk_splitter_crc_check_core
// Byte-stream chunk parser and CRC-32 checker for PNG, MNG and JNG files.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): one file byte per request, with
//   i_last_byte set on the final byte of a file.
//   Output channel (o_valid / i_ready): one result per input byte: the byte,
//   its section, chunk number, chunk-done flag, status and file kind.
//   Pipeline: the accepted byte is first held in the input register, then its
//   parse result is loaded into the result register, which raises o_valid.
//   Throughput: 1 byte per cycle while the receiver takes results, set by
//   the byte-wide CRC-32 update and field counters evaluated combinationally.
//   Reset (i_rst_n low, synchronous): both pipeline stages empty, parser
//   back to the signature phase. The parser also returns to that state
//   after each last byte, so files may follow back to back.
//   Receiver stall: the result register holds; the input register keeps
//   one more byte, then o_ready drops until the result is taken.
//   After a bad signature or bad CRC the rest of the file is reported as
//   ignored (section 5) until the last-byte mark.
// ----------------------------------------------------------------------------
module png_chunk_splitter_crc_check_core
    import pngcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte_out,
    output logic [2:0]  o_section,
    output logic [31:0] o_chunk_number,
    output logic        o_chunk_done,
    output logic [2:0]  o_status,
    output logic [1:0]  o_file_kind
);

    // input stage
    logic         r_in_vld;
    logic [7:0]   r_in_data;
    logic         r_in_last;

    // parser state and result stage
    t_parse_state r_st;
    t_parse_state n_st;
    logic         r_out_vld;
    t_result      r_out;
    t_result      n_out;

    // the held byte moves into the result register when that slot is free
    logic         w_adv;

    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;

    pngcc_step u_step (
        .i_state     (r_st),
        .i_data_byte (r_in_data),
        .i_last_byte (r_in_last),
        .o_next      (n_st),
        .o_result    (n_out)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= PARSE_RESET;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_adv) begin
                r_st      <= n_st;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_byte_out     = r_out.byte_out;
    assign o_section      = r_out.section;
    assign o_chunk_number = r_out.chunk_number;
    assign o_chunk_done   = r_out.chunk_done;
    assign o_status       = r_out.status;
    assign o_file_kind    = r_out.file_kind;

`ifndef SYNTHESIS
    // a last byte always returns the parser to its reset state
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_st == PARSE_RESET))
        else $error("parser state not cleared after last byte");

    // byte counter never passes its saturation point
    a_bytes_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.bytes_seen <= MIN_FILE_BYTES)
        else $error("byte counter overflow");

    // chunk completion only on a CRC byte
    a_done_in_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_chunk_done) |-> (o_section == SEC_CRC))
        else $error("chunk_done outside CRC field");

    // ignored bytes carry no error other than a short-file report
    a_ignored_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_section == SEC_IGNORED) |->
            (o_status == ST_OK || o_status == ST_BAD_SIG))
        else $error("bad status on ignored byte");
`endif

endmodule

// ===== hw/rtl/pngcc_step.sv =====
// ----------------------------------------------------------------------------
// pngcc_step
// Per-byte parser update: next state and the result for one file byte.
// ----------------------------------------------------------------------------
module pngcc_step
    import pngcc_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_data_byte,
    input  logic         i_last_byte,
    output t_parse_state o_next,
    output t_result      o_result
);

    t_parse_state nx;
    logic [2:0]   sec;
    logic [31:0]  num;
    logic         done;
    logic [2:0]   status;
    logic [1:0]   kind;
    logic [31:0]  cnt_inc;
    logic [31:0]  len_base;
    logic [31:0]  rcv_next;
    logic         short_file;

    assign cnt_inc    = i_state.chunk_cnt + 32'd1;
    assign len_base   = (i_state.fbc == 3'd0) ? 32'd0 : i_state.data_rem;
    assign rcv_next   = {i_state.crc_rcv[23:0], i_data_byte};
    assign short_file = i_last_byte && (i_state.bytes_seen < (MIN_FILE_BYTES - 7'd1));

    always_comb begin
        nx     = i_state;
        sec    = SEC_IGNORED;
        num    = i_state.chunk_cnt;
        done   = 1'b0;
        status = ST_OK;

        if (i_state.bytes_seen < MIN_FILE_BYTES) begin
            nx.bytes_seen = i_state.bytes_seen + 7'd1;
        end

        if (!i_state.stopped) begin
            unique case (i_state.phase)
                PH_SIG: begin
                    sec = SEC_SIG;
                    num = 32'd0;
                    for (int k = 0; k < 3; k++) begin
                        if (SIG_TABLE[k][i_state.fbc] != i_data_byte) begin
                            nx.sig_match[k] = 1'b0;
                        end
                    end
                    nx.fbc = i_state.fbc + 3'd1;
                    if (nx.fbc == 3'd0) begin
                        if (nx.sig_match == 3'b000) begin
                            status     = ST_BAD_SIG;
                            nx.stopped = 1'b1;
                        end else begin
                            nx.phase = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    sec = SEC_LEN;
                    if (i_state.fbc == 3'd0) begin
                        nx.chunk_cnt = cnt_inc;
                    end
                    num         = nx.chunk_cnt;
                    nx.data_rem = {len_base[23:0], i_data_byte};
                    if (i_state.fbc >= 3'd3) begin
                        nx.fbc     = 3'd0;
                        nx.crc_run = CRC_INIT;
                        nx.phase   = PH_TYPE;
                    end else begin
                        nx.fbc = i_state.fbc + 3'd1;
                    end
                end
                PH_TYPE: begin
                    sec        = SEC_TYPE;
                    nx.crc_run = crc32_byte(i_state.crc_run, i_data_byte);
                    if (i_state.fbc >= 3'd3) begin
                        nx.fbc   = 3'd0;
                        nx.phase = (i_state.data_rem != 32'd0) ? PH_DATA : PH_CRC;
                    end else begin
                        nx.fbc = i_state.fbc + 3'd1;
                    end
                end
                PH_DATA: begin
                    sec         = SEC_DATA;
                    nx.crc_run  = crc32_byte(i_state.crc_run, i_data_byte);
                    nx.data_rem = i_state.data_rem - 32'd1;
                    if (i_state.data_rem == 32'd1) begin
                        nx.phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    sec        = SEC_CRC;
                    nx.crc_rcv = rcv_next;
                    if (i_state.fbc >= 3'd3) begin
                        nx.fbc = 3'd0;
                        done   = 1'b1;
                        if (~i_state.crc_run != rcv_next) begin
                            status     = ST_BAD_CRC;
                            nx.stopped = 1'b1;
                        end else begin
                            nx.phase = PH_LEN;
                        end
                    end else begin
                        nx.fbc = i_state.fbc + 3'd1;
                    end
                end
                default: begin
                    sec        = SEC_IGNORED;
                    nx.stopped = 1'b1;
                end
            endcase
        end

        if (nx.phase == PH_SIG) begin
            kind = KIND_NONE;
        end else begin
            priority if (nx.sig_match[0]) kind = KIND_PNG;
            else if (nx.sig_match[1])     kind = KIND_MNG;
            else if (nx.sig_match[2])     kind = KIND_JNG;
            else                          kind = KIND_NONE;
        end

        if (i_last_byte) begin
            if (short_file) begin
                status = ST_BAD_SIG;
            end else if (!i_state.stopped && status == ST_OK) begin
                status = (nx.phase == PH_DATA) ? ST_END_DATA : ST_END_CLEAN;
            end
        end
    end

    assign o_next = i_last_byte ? PARSE_RESET : nx;

    assign o_result = '{
        byte_out:     i_data_byte,
        section:      sec,
        chunk_number: num,
        chunk_done:   done,
        status:       status,
        file_kind:    kind
    };

endmodule
